### rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; the caller supplies clock, reset and the two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SBBA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbba assertion failed");

// Next-cycle implication, disabled during reset.
`define SBBA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbba assertion failed");

`endif

### rtl/core/sbba_pkg.sv
// Package for the swap block bitmap allocator: sizes, codes, types and the
// byte scan helper. No dependencies.
package sbba_pkg;

   localparam int NUM_BLOCKS    = 1024;
   localparam int BYTES_SCANNED = 128;
   localparam int BITS_PER_BYTE = 8;
   localparam int MAP_BYTES     = (NUM_BLOCKS + BITS_PER_BYTE - 1) / BITS_PER_BYTE;
   localparam int SCAN_LIMIT    = (BYTES_SCANNED < MAP_BYTES) ? BYTES_SCANNED : MAP_BYTES;

   localparam int ADDR_W     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int SCAN_CNT_W = $clog2(SCAN_LIMIT + 1);
   localparam int OP_W       = 2;
   localparam int BLOCK_W    = 10;
   localparam int COUNT_W    = 11;

   typedef logic [OP_W-1:0]       op_type;
   typedef logic [BLOCK_W-1:0]    block_type;
   typedef logic [COUNT_W-1:0]    count_type;
   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [SCAN_CNT_W-1:0] scan_cnt_type;
   typedef logic [7:0]            byte_type;
   typedef logic [2:0]            bit_pos_type;

   localparam op_type OP_FIND  = 2'd0;
   localparam op_type OP_SET   = 2'd1;
   localparam op_type OP_CLEAR = 2'd2;

   localparam byte_type BYTE_FULL = 8'hFF;
   localparam byte_type TOP_BIT   = 8'h80;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RMW_RD,
      ST_RMW_WR,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic     rd_en;
      addr_type rd_addr;
      logic     wr_en;
      addr_type wr_addr;
      byte_type wr_data;
   } map_req_type;

   // Position of the first zero bit, scanning from the MSB down.
   function automatic bit_pos_type first_free_pos(input byte_type b);
      bit_pos_type pos;
      pos = 3'd0;
      for (int s = BITS_PER_BYTE - 1; s >= 0; s--) begin
         if (!b[BITS_PER_BYTE - 1 - s]) begin
            pos = bit_pos_type'(s);
         end
      end
      return pos;
   endfunction

endpackage

### rtl/core/sbba_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on sbba_pkg.
interface sbba_req_if;
   logic               valid;
   logic               ready;
   sbba_pkg::op_type    operation;
   sbba_pkg::block_type block_index;

   modport source (output valid, output operation, output block_index, input ready);
   modport sink   (input valid, input operation, input block_index, output ready);
endinterface

interface sbba_rsp_if;
   logic               valid;
   logic               ready;
   logic               found;
   sbba_pkg::block_type free_block;
   sbba_pkg::count_type free_count;

   modport source (output valid, output found, output free_block, output free_count,
                   input ready);
   modport sink   (input valid, input found, input free_block, input free_count,
                   output ready);
endinterface

### rtl/core/sbba_map.sv
// Bitmap store: one byte per entry, one read and one write port, registered
// read. Per-entry valid bits make unwritten bytes read as all free. Uses sbba_pkg.
module sbba_map (
   input  logic                  clock,
   input  logic                  reset,
   input  sbba_pkg::map_req_type map_req,
   output sbba_pkg::byte_type    rd_data
);

   sbba_pkg::byte_type                mem_ff [sbba_pkg::MAP_BYTES];
   logic [sbba_pkg::MAP_BYTES-1:0]    valid_ff;
   sbba_pkg::byte_type                rd_data_ff;

   always_ff @(posedge clock) begin
      if (map_req.wr_en) begin
         mem_ff[map_req.wr_addr] <= map_req.wr_data;
      end
      if (map_req.rd_en) begin
         rd_data_ff <= valid_ff[map_req.rd_addr] ? mem_ff[map_req.rd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (map_req.wr_en) begin
         valid_ff[map_req.wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/sbba_ctrl.sv
// Sequencer for the allocator: byte-at-a-time free search, read-modify-write
// for mark used/free, free counter and response register. Uses sbba_pkg, sbba_if.
module sbba_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   sbba_req_if.sink              req_ch,
   sbba_rsp_if.source            rsp_ch,
   output sbba_pkg::map_req_type map_req,
   input  sbba_pkg::byte_type    map_rd_data
);

   sbba_pkg::state_type    state_ff, state_in;
   sbba_pkg::op_type       op_ff, op_in;
   sbba_pkg::block_type    blk_ff, blk_in;
   sbba_pkg::scan_cnt_type iss_ff, iss_in;
   logic                   chk_vld_ff, chk_vld_in;
   sbba_pkg::addr_type     chk_addr_ff, chk_addr_in;
   logic                   res_found_ff, res_found_in;
   sbba_pkg::block_type    res_block_ff, res_block_in;
   sbba_pkg::count_type    count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   sbba_pkg::block_type    rsp_block_ff, rsp_block_in;
   sbba_pkg::count_type    rsp_count_ff, rsp_count_in;

   logic [sbba_pkg::ADDR_W+2:0] hit_blk;
   sbba_pkg::byte_type          bit_mask;
   sbba_pkg::addr_type          blk_byte;

   assign hit_blk  = {chk_addr_ff, sbba_pkg::first_free_pos(map_rd_data)};
   assign bit_mask = sbba_pkg::TOP_BIT >> blk_ff[2:0];
   assign blk_byte = sbba_pkg::addr_type'(blk_ff >> 3);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbba_pkg::ST_IDLE;
         count_ff     <= sbba_pkg::count_type'(sbba_pkg::NUM_BLOCKS);
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      blk_ff       <= blk_in;
      iss_ff       <= iss_in;
      chk_addr_ff  <= chk_addr_in;
      res_found_ff <= res_found_in;
      res_block_ff <= res_block_in;
      rsp_found_ff <= rsp_found_in;
      rsp_block_ff <= rsp_block_in;
      rsp_count_ff <= rsp_count_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      blk_in       = blk_ff;
      iss_in       = iss_ff;
      chk_vld_in   = chk_vld_ff;
      chk_addr_in  = chk_addr_ff;
      res_found_in = res_found_ff;
      res_block_in = res_block_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_block_in = rsp_block_ff;
      rsp_count_in = rsp_count_ff;
      map_req      = '0;

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         sbba_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               op_in        = req_ch.operation;
               blk_in       = req_ch.block_index;
               res_found_in = 1'b0;
               res_block_in = '0;
               if (req_ch.operation == sbba_pkg::OP_FIND) begin
                  if (count_ff == '0) begin
                     state_in = sbba_pkg::ST_SEND;
                  end else begin
                     iss_in     = '0;
                     chk_vld_in = 1'b0;
                     state_in   = sbba_pkg::ST_SCAN;
                  end
               end else if ((req_ch.operation == sbba_pkg::OP_SET ||
                             req_ch.operation == sbba_pkg::OP_CLEAR) &&
                            32'(req_ch.block_index) < sbba_pkg::NUM_BLOCKS) begin
                  state_in = sbba_pkg::ST_RMW_RD;
               end else begin
                  state_in = sbba_pkg::ST_SEND;
               end
            end
         end

         sbba_pkg::ST_SCAN: begin
            // issue one byte per cycle, check the byte issued in the cycle before
            if (32'(iss_ff) < sbba_pkg::SCAN_LIMIT) begin
               map_req.rd_en   = 1'b1;
               map_req.rd_addr = sbba_pkg::addr_type'(iss_ff);
               iss_in          = sbba_pkg::scan_cnt_type'(iss_ff + 1'b1);
               chk_vld_in      = 1'b1;
               chk_addr_in     = sbba_pkg::addr_type'(iss_ff);
            end else begin
               chk_vld_in = 1'b0;
            end
            if (chk_vld_ff) begin
               if (map_rd_data != sbba_pkg::BYTE_FULL) begin
                  // a free bit past the last block means nothing usable
                  if (32'(hit_blk) < sbba_pkg::NUM_BLOCKS) begin
                     res_found_in = 1'b1;
                     res_block_in = sbba_pkg::block_type'(hit_blk);
                  end
                  chk_vld_in = 1'b0;
                  state_in   = sbba_pkg::ST_SEND;
               end else if (chk_addr_ff == sbba_pkg::addr_type'(sbba_pkg::SCAN_LIMIT - 1)) begin
                  chk_vld_in = 1'b0;
                  state_in   = sbba_pkg::ST_SEND;
               end
            end
         end

         sbba_pkg::ST_RMW_RD: begin
            map_req.rd_en   = 1'b1;
            map_req.rd_addr = blk_byte;
            state_in        = sbba_pkg::ST_RMW_WR;
         end

         sbba_pkg::ST_RMW_WR: begin
            map_req.wr_en   = 1'b1;
            map_req.wr_addr = blk_byte;
            if (op_ff == sbba_pkg::OP_SET) begin
               map_req.wr_data = map_rd_data | bit_mask;
               if (count_ff != '0) begin
                  count_in = sbba_pkg::count_type'(count_ff - 1'b1);
               end
            end else begin
               map_req.wr_data = map_rd_data & ~bit_mask;
               if (32'(count_ff) < sbba_pkg::NUM_BLOCKS) begin
                  count_in = sbba_pkg::count_type'(count_ff + 1'b1);
               end
            end
            state_in = sbba_pkg::ST_SEND;
         end

         sbba_pkg::ST_SEND: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_block_in = res_block_ff;
               rsp_count_in = count_ff;
               state_in     = sbba_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sbba_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_ch.ready      = (state_ff == sbba_pkg::ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.found      = rsp_found_ff;
   assign rsp_ch.free_block = rsp_block_ff;
   assign rsp_ch.free_count = rsp_count_ff;

endmodule

### rtl/core/swap_block_bitmap_allocator.sv
// Swap block bitmap allocator: one used/free bit per swap block (block n is
// bit 0x80 >> (n % 8) of byte n / 8) plus a saturating free-block counter.
// One request beat yields one response beat. A find walks the bitmap store
// one byte per cycle through its single read port, up to SCAN_LIMIT bytes,
// stopping early when a free bit turns up; with a zero counter it answers
// without a scan. Mark used/free is a read-modify-write of one byte; an
// unused code or an out-of-range block answers without touching the map.
// One request is worked at a time; a new one is taken while the previous
// response waits.
// Reset is immediate: per-byte valid bits make the whole map read as free.
// Depends on sbba_pkg, sbba_if, sbba_map and sbba_ctrl.
module swap_block_bitmap_allocator (
   input  logic       clock,
   input  logic       reset,
   sbba_req_if.sink   req_ch,
   sbba_rsp_if.source rsp_ch
);

   sbba_pkg::map_req_type map_req;
   sbba_pkg::byte_type    map_rd_data;

   sbba_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .map_req     (map_req),
      .map_rd_data (map_rd_data)
   );

   sbba_map u_map (
      .clock   (clock),
      .reset   (reset),
      .map_req (map_req),
      .rd_data (map_rd_data)
   );

endmodule

### rtl/core/sbba_checker.sv
// Port-level checks for the allocator, bound to the top level.
// Depends on sbba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sbba_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_found,
   input sbba_pkg::block_type rsp_free_block,
   input sbba_pkg::count_type rsp_free_count
);

   // a hit is only possible with a nonzero counter
   `SBBA_ASSERT_NOW(a_found_needs_count, clock, reset, rsp_valid && rsp_found, rsp_free_count != '0)
   `SBBA_ASSERT_NOW(a_miss_zero_block, clock, reset, rsp_valid && !rsp_found, rsp_free_block == '0)
   `SBBA_ASSERT_NOW(a_count_bound, clock, reset, rsp_valid, 32'(rsp_free_count) <= sbba_pkg::NUM_BLOCKS)
   // an accepted request takes the block out of idle, so ready drops
   `SBBA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind swap_block_bitmap_allocator sbba_checker u_sbba_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_found      (rsp_ch.found),
   .rsp_free_block (rsp_ch.free_block),
   .rsp_free_count (rsp_ch.free_count)
);

### test/swap_block_bitmap_allocator_tb.sv
// Testbench for swap_block_bitmap_allocator: a directed table and random allocate/free
// traffic, with every response checked against its table row or a bitmap predictor.
// Depends on sbba_pkg, sbba_if and the allocator RTL.
`timescale 1ns / 1ps

module swap_block_bitmap_allocator_tb;
   import sbba_pkg::*;

   localparam op_type OP_UNUSED    = 2'd3;
   localparam int     ROW_COUNT    = 18;
   localparam int     RANDOM_ITEMS = 380;
   localparam int     HOLD_CYCLES  = 300;
   localparam int     IDLE_LIMIT   = 4000;
   localparam int     TAIL_CYCLES  = 150;

   typedef struct packed {
      logic      found;
      block_type free_block;
      count_type free_count;
   } alloc_result_type;

   typedef struct {
      op_type    op;
      block_type blk;
      bit        typed;
      logic      found;
      block_type free_block;
      count_type free_count;
   } directed_row_type;

   // typed = 1: expected response is given here; typed = 0: predictor decides
   directed_row_type plan [ROW_COUNT] = '{
      '{OP_FIND,    10'd1023, 1'b1, 1'b1, 10'd0,    11'd1024},
      '{OP_SET,     10'd0,    1'b1, 1'b0, 10'd0,    11'd1023},
      '{OP_SET,     10'd1023, 1'b1, 1'b0, 10'd0,    11'd1022},
      '{OP_FIND,    10'd0,    1'b1, 1'b1, 10'd1,    11'd1022},
      '{OP_SET,     10'd0,    1'b1, 1'b0, 10'd0,    11'd1021},  // bit already used
      '{OP_CLEAR,   10'd0,    1'b1, 1'b0, 10'd0,    11'd1022},
      '{OP_CLEAR,   10'd0,    1'b1, 1'b0, 10'd0,    11'd1023},  // bit already free
      '{OP_CLEAR,   10'd1023, 1'b1, 1'b0, 10'd0,    11'd1024},
      '{OP_CLEAR,   10'd512,  1'b1, 1'b0, 10'd0,    11'd1024},  // saturates at top
      '{OP_UNUSED,  10'd1023, 1'b1, 1'b0, 10'd0,    11'd1024},
      '{OP_SET,     10'd1,    1'b1, 1'b0, 10'd0,    11'd1023},
      '{OP_FIND,    10'd0,    1'b0, 1'b0, 10'd0,    11'd0},
      '{OP_SET,     10'd0,    1'b0, 1'b0, 10'd0,    11'd0},
      '{OP_SET,     10'd2,    1'b0, 1'b0, 10'd0,    11'd0},
      '{OP_FIND,    10'd511,  1'b0, 1'b0, 10'd0,    11'd0},
      '{OP_CLEAR,   10'd1,    1'b0, 1'b0, 10'd0,    11'd0},
      '{OP_FIND,    10'd0,    1'b0, 1'b0, 10'd0,    11'd0},
      '{OP_UNUSED,  10'd5,    1'b1, 1'b0, 10'd0,    11'd1022}
   };

   logic clock;
   logic reset;

   sbba_req_if req_bus ();
   sbba_rsp_if rsp_bus ();

   swap_block_bitmap_allocator DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // predictor state
   byte_type         used_map [MAP_BYTES];
   int               free_blocks;
   alloc_result_type pending_results [$];

   int sender_idle_pct;
   int receiver_stall_pct;
   bit hold_request;
   int mismatch_count;
   int idle_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic alloc_result_type predict_alloc(input op_type op, input block_type blk);
      alloc_result_type r;
      bit               done;
      int               n;
      r    = '0;
      done = 1'b0;
      if (op == OP_FIND) begin
         if (free_blocks != 0) begin
            for (int i = 0; i < SCAN_LIMIT && !done; i++) begin
               if (used_map[i] != BYTE_FULL) begin
                  for (int s = 0; s < BITS_PER_BYTE && !done; s++) begin
                     n = i * BITS_PER_BYTE + s;
                     if (n >= NUM_BLOCKS) begin
                        done = 1'b1;
                     end else if ((used_map[i] & (TOP_BIT >> s)) == 8'h00) begin
                        r.found      = 1'b1;
                        r.free_block = block_type'(n);
                        done         = 1'b1;
                     end
                  end
               end
            end
         end
      end else if ((op == OP_SET || op == OP_CLEAR) && int'(blk) < NUM_BLOCKS) begin
         if (op == OP_SET) begin
            if (free_blocks > 0) free_blocks--;
            used_map[blk / BITS_PER_BYTE] |= TOP_BIT >> (blk % BITS_PER_BYTE);
         end else begin
            if (free_blocks < NUM_BLOCKS) free_blocks++;
            used_map[blk / BITS_PER_BYTE] &= ~(TOP_BIT >> (blk % BITS_PER_BYTE));
         end
      end
      r.free_count = count_type'(free_blocks);
      return r;
   endfunction

   // Offer one request beat; on acceptance record what the response must be.
   task automatic issue(input op_type op, input block_type blk, input bit typed,
                        input alloc_result_type typed_res,
                        output alloc_result_type predicted);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.operation   <= op;
      req_bus.block_index <= blk;
      do @(posedge clock); while (!req_bus.ready);
      predicted = predict_alloc(op, blk);
      pending_results.push_back(typed ? typed_res : predicted);
   endtask

   // response side: random stalls plus one long hold-off on request
   initial begin : receiver
      int hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response beat: expected none, got found=%0d block=%0d count=%0d",
                     $time, rsp_bus.found, rsp_bus.free_block, rsp_bus.free_count);
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.found !== want.found || rsp_bus.free_block !== want.free_block ||
                rsp_bus.free_count !== want.free_count) begin
               mismatch_count++;
               $display("%0t: response mismatch: expected found=%0d block=%0d count=%0d, got found=%0d block=%0d count=%0d",
                        $time, want.found, want.free_block, want.free_count,
                        rsp_bus.found, rsp_bus.free_block, rsp_bus.free_count);
            end
         end
      end
   end

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      alloc_result_type res;
      alloc_result_type row_res;
      int               items;
      int               pick;
      bit               pressure_done;

      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.operation   = OP_FIND;
      req_bus.block_index = '0;
      hold_request        = 1'b0;
      mismatch_count      = 0;
      idle_cycles         = 0;
      pressure_done       = 1'b0;
      free_blocks         = NUM_BLOCKS;
      foreach (used_map[i]) used_map[i] = 8'h00;
      sender_idle_pct     = 31;
      receiver_stall_pct  = 57;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < ROW_COUNT; r++) begin
         row_res = '{plan[r].found, plan[r].free_block, plan[r].free_count};
         issue(plan[r].op, plan[r].blk, plan[r].typed, row_res, res);
      end

      items = 0;
      while (items < RANDOM_ITEMS) begin
         if (items >= 270) begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end else if (items >= 135) begin
            sender_idle_pct    = 57;
            receiver_stall_pct = 31;
         end
         if (items >= 300 && !pressure_done) begin
            hold_request  = 1'b1;
            pressure_done = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 35) begin
            // allocate: find, then claim what was found
            issue(OP_FIND, block_type'($urandom), 1'b0, '0, res);
            items++;
            if (res.found) begin
               issue(OP_SET, res.free_block, 1'b0, '0, res);
               items++;
            end
         end else if (pick < 65) begin
            issue(OP_CLEAR, block_type'($urandom_range(NUM_BLOCKS - 1)), 1'b0, '0, res);
            items++;
         end else if (pick < 75) begin
            issue(OP_SET, block_type'($urandom_range(NUM_BLOCKS - 1)), 1'b0, '0, res);
            items++;
         end else if (pick < 90) begin
            issue(OP_FIND, block_type'($urandom), 1'b0, '0, res);
            items++;
         end else begin
            issue(OP_UNUSED, block_type'($urandom), 1'b0, '0, res);
            items++;
         end
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
